/* hw/rtl/cctb_pkg.sv */
// Shared types and constants for the charge-conserving ternary blocking block.
package cctb_pkg;

    localparam int MAX_COARSE_SITES_DEF = 64;
    localparam int CMD_DEPTH            = 2;
    localparam int RES_DEPTH            = 2;
    localparam int CNT_W                = 9;
    localparam int MAG_W                = 3;
    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    localparam logic [1:0] TERN_ZERO = 2'b00;
    localparam logic [1:0] TERN_POS  = 2'b01;
    localparam logic [1:0] TERN_NEG  = 2'b11;

    typedef enum logic [1:0] {
        CMD_ZERO = 2'd0,
        CMD_POS  = 2'd1,
        CMD_NEG  = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [MAG_W-1:0] mag;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       coarse_state;
        logic             site_last;
        logic [CNT_W-1:0] unplaced_positive;
        logic [CNT_W-1:0] unplaced_negative;
        logic             conserved;
    } result_t;

endpackage

/* hw/rtl/charge_conserving_ternary_blocking.sv */
// Charge-conserving ternary blocking: top level.
//
// Input queue side: present child0..child7 and last_block and raise push;
// a transaction completes on a clock edge with push high and full low.
// Result queue side: while empty is low the oldest result is on
// coarse_state, site_last, unplaced_positive, unplaced_negative and
// conserved; a transaction completes on an edge with pop high.
// One result per input item, in order. An accepted item is registered in
// the command queue and then in the result queue before it reaches the
// outputs; the block sustains one item per cycle while the result queue
// has room. The spill memory keeps its head entry in a register and
// prefetches the next, so a zero-sum site emptying the head never stalls.
// A two-entry command queue sits between the classifier and the spill
// engine, and a two-entry result queue sits after it; when pop is held low
// the result queue fills, then the command queue, then full rises.
// Reset (rst_n low) empties both queues and clears the spill queue and the
// pending counters; no clearing pass is needed. A last_block item reports
// the unplaced units and clears the spill queue and the pending counters.
module charge_conserving_ternary_blocking #(
    parameter int MAX_COARSE_SITES = cctb_pkg::MAX_COARSE_SITES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic signed [1:0] child0,
    input  logic signed [1:0] child1,
    input  logic signed [1:0] child2,
    input  logic signed [1:0] child3,
    input  logic signed [1:0] child4,
    input  logic signed [1:0] child5,
    input  logic signed [1:0] child6,
    input  logic signed [1:0] child7,
    input  logic              last_block,
    output logic              empty,
    input  logic              pop,
    output logic signed [1:0] coarse_state,
    output logic              site_last,
    output logic [8:0]        unplaced_positive,
    output logic [8:0]        unplaced_negative,
    output logic              conserved
);
    import cctb_pkg::*;

    cmd_t    front_cmd;
    cmd_t    back_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_full;
    logic    res_push;
    result_t back_res;
    result_t out_res;

    cctb_front u_front (
        .child0     (child0),
        .child1     (child1),
        .child2     (child2),
        .child3     (child3),
        .child4     (child4),
        .child5     (child5),
        .child6     (child6),
        .child7     (child7),
        .last_block (last_block),
        .cmd        (front_cmd)
    );

    cctb_fifo #(
        .W     ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    cctb_back #(
        .MAX_COARSE_SITES (MAX_COARSE_SITES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    cctb_fifo #(
        .W     ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign coarse_state      = out_res.coarse_state;
    assign site_last         = out_res.site_last;
    assign unplaced_positive = out_res.unplaced_positive;
    assign unplaced_negative = out_res.unplaced_negative;
    assign conserved         = out_res.conserved;

endmodule

/* hw/rtl/cctb_fifo.sv */
// Small first-word-fall-through queue of packed words.
module cctb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/cctb_front.sv */
// Front end: sums the eight children of a block and classifies the net charge.
module cctb_front (
    input  logic signed [1:0] child0,
    input  logic signed [1:0] child1,
    input  logic signed [1:0] child2,
    input  logic signed [1:0] child3,
    input  logic signed [1:0] child4,
    input  logic signed [1:0] child5,
    input  logic signed [1:0] child6,
    input  logic signed [1:0] child7,
    input  logic              last_block,
    output cctb_pkg::cmd_t    cmd
);
    import cctb_pkg::*;

    logic [1:0]        raw [8];
    logic signed [4:0] sum;
    logic [4:0]        abs_sum;

    assign raw[0] = child0;
    assign raw[1] = child1;
    assign raw[2] = child2;
    assign raw[3] = child3;
    assign raw[4] = child4;
    assign raw[5] = child5;
    assign raw[6] = child6;
    assign raw[7] = child7;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            unique case (raw[i])
                2'b00:   sum = sum;
                2'b01:   sum = sum + 5'sd1;
                default: sum = sum - 5'sd1;
            endcase
        end
        abs_sum  = sum[4] ? 5'(-sum) : 5'(sum);
        cmd.last = last_block;
        if (sum == '0)
        begin
            cmd.op  = CMD_ZERO;
            cmd.mag = '0;
        end
        else
        begin
            cmd.op  = sum[4] ? CMD_NEG : CMD_POS;
            cmd.mag = MAG_W'(abs_sum - 5'd1);
        end
    end

endmodule

/* hw/rtl/cctb_back.sv */
// Back end: spill queue, pending counters and resolution of each coarse site.
module cctb_back #(
    parameter int MAX_COARSE_SITES = cctb_pkg::MAX_COARSE_SITES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cctb_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output cctb_pkg::result_t res
);
    import cctb_pkg::*;

    localparam int PW  = (MAX_COARSE_SITES > 1) ? $clog2(MAX_COARSE_SITES) : 1;
    localparam int MCW = $clog2(MAX_COARSE_SITES + 1);
    localparam int EW  = MAG_W + 1;

    logic [EW-1:0]    mem [MAX_COARSE_SITES];
    logic [EW-1:0]    mem_rdata_reg;
    logic [EW-1:0]    byp_data_reg;
    logic             byp_hit_reg;
    logic [EW-1:0]    head_entry;

    logic             hv_reg, hv_next;
    logic             h_neg_reg, h_neg_next;
    logic [MAG_W-1:0] h_mag_reg, h_mag_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [MCW-1:0]   mcount_reg, mcount_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] neg_reg, neg_next;

    logic             go;
    logic             spill;
    logic             take;
    logic             is_neg;
    logic             mem_we;
    logic [EW-1:0]    mem_wdata;
    logic [CNT_W:0]   pos_sum;
    logic [CNT_W:0]   neg_sum;

    assign go         = !cmd_empty && !res_full;
    assign cmd_pop    = go;
    assign res_push   = go;
    assign head_entry = byp_hit_reg ? byp_data_reg : mem_rdata_reg;
    assign is_neg     = (cmd.op == CMD_NEG);
    assign spill      = (cmd.op != CMD_ZERO) && (cmd.mag != '0);
    assign take       = (cmd.op == CMD_ZERO) && hv_reg;
    assign pos_sum    = {1'b0, pos_reg} + (CNT_W + 1)'(cmd.mag);
    assign neg_sum    = {1'b0, neg_reg} + (CNT_W + 1)'(cmd.mag);
    assign mem_wdata  = {is_neg, cmd.mag};

    always_comb
    begin
        hv_next     = hv_reg;
        h_neg_next  = h_neg_reg;
        h_mag_next  = h_mag_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        mcount_next = mcount_reg;
        pos_next    = pos_reg;
        neg_next    = neg_reg;
        mem_we      = 1'b0;

        unique case (cmd.op)
            CMD_POS:  res.coarse_state = TERN_POS;
            CMD_NEG:  res.coarse_state = TERN_NEG;
            default:  res.coarse_state = hv_reg ? (h_neg_reg ? TERN_NEG : TERN_POS) : TERN_ZERO;
        endcase

        if (go && spill)
        begin
            if (is_neg)
            begin
                neg_next = neg_sum[CNT_W] ? CNT_MAX : neg_sum[CNT_W-1:0];
            end
            else
            begin
                pos_next = pos_sum[CNT_W] ? CNT_MAX : pos_sum[CNT_W-1:0];
            end
            if (!hv_reg)
            begin
                hv_next    = 1'b1;
                h_neg_next = is_neg;
                h_mag_next = cmd.mag;
            end
            else if (mcount_reg < MCW'(MAX_COARSE_SITES - 1))
            begin
                mem_we      = 1'b1;
                wr_ptr_next = (wr_ptr_reg == PW'(MAX_COARSE_SITES - 1)) ? '0 : wr_ptr_reg + 1'b1;
                mcount_next = mcount_reg + 1'b1;
            end
        end
        else if (go && take)
        begin
            if (h_neg_reg)
            begin
                if (neg_reg != '0)
                begin
                    neg_next = neg_reg - 1'b1;
                end
            end
            else if (pos_reg != '0)
            begin
                pos_next = pos_reg - 1'b1;
            end
            if (h_mag_reg == MAG_W'(1))
            begin
                if (mcount_reg != '0)
                begin
                    h_neg_next  = head_entry[EW-1];
                    h_mag_next  = head_entry[MAG_W-1:0];
                    rd_ptr_next = (rd_ptr_reg == PW'(MAX_COARSE_SITES - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    mcount_next = mcount_reg - 1'b1;
                end
                else
                begin
                    hv_next = 1'b0;
                end
            end
            else
            begin
                h_mag_next = h_mag_reg - 1'b1;
            end
        end

        res.site_last = cmd.last;
        if (cmd.last)
        begin
            res.unplaced_positive = pos_next;
            res.unplaced_negative = neg_next;
            res.conserved         = (pos_next == '0) && (neg_next == '0);
            if (go)
            begin
                hv_next     = 1'b0;
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                mcount_next = '0;
                pos_next    = '0;
                neg_next    = '0;
            end
        end
        else
        begin
            res.unplaced_positive = '0;
            res.unplaced_negative = '0;
            res.conserved         = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= mem_wdata;
        end
        mem_rdata_reg <= mem[rd_ptr_next];
        byp_data_reg  <= mem_wdata;
        h_neg_reg     <= h_neg_next;
        h_mag_reg     <= h_mag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
            hv_reg      <= 1'b0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            mcount_reg  <= '0;
            pos_reg     <= '0;
            neg_reg     <= '0;
        end
        else
        begin
            byp_hit_reg <= mem_we && (wr_ptr_reg == rd_ptr_next);
            hv_reg      <= hv_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            mcount_reg  <= mcount_next;
            pos_reg     <= pos_next;
            neg_reg     <= neg_next;
        end
    end

endmodule

/* hw/rtl/cctb_checker.sv */
// Port-level checks for the charge-conserving ternary blocking block, with bind.
module cctb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic signed [1:0] coarse_state,
    input logic              site_last,
    input logic [8:0]        unplaced_positive,
    input logic [8:0]        unplaced_negative,
    input logic              conserved
);

    a_mid_site_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !site_last) |->
            (unplaced_positive == 9'd0 && unplaced_negative == 9'd0 && !conserved))
        else $error("summary fields set on a site that is not the last");

    a_conserved_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && site_last) |->
            (conserved == (unplaced_positive == 9'd0 && unplaced_negative == 9'd0)))
        else $error("conserved flag disagrees with unplaced counts");

    a_ternary_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (coarse_state != 2'sb10))
        else $error("coarse state outside the ternary range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(coarse_state) && $stable(site_last)
             && $stable(unplaced_positive) && $stable(unplaced_negative)))
        else $error("waiting result changed while stalled");

endmodule

bind charge_conserving_ternary_blocking cctb_checker u_cctb_checker (.*);

/* tb/tb_charge_conserving_ternary_blocking.sv */
// Testbench for the charge-conserving ternary blocking block: streamed lattices checked per site.
module tb_charge_conserving_ternary_blocking;
    timeunit 1ns;
    timeprecision 1ps;

    import cctb_pkg::*;

    localparam int          SITES        = MAX_COARSE_SITES_DEF;
    localparam logic [1:0]  TERN_NEG_SAT = 2'b10;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          CALM_ITEMS   = 130;

    class coarse_site_tracker;
        logic       spill_sign [SITES];
        logic [2:0] spill_mag  [SITES];
        int         head;
        int         tail;
        int         count;
        logic [CNT_W-1:0] owed_pos;
        logic [CNT_W-1:0] owed_neg;
        result_t    expected_sites [$];
        int         mismatches;

        function new();
            clear_spills();
            mismatches = 0;
        endfunction

        function void clear_spills();
            head     = 0;
            tail     = 0;
            count    = 0;
            owed_pos = '0;
            owed_neg = '0;
        endfunction

        function logic [CNT_W-1:0] owe_more(logic [CNT_W-1:0] owed, int units);
            int total;
            total = int'(owed) + units;
            return (total > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(total);
        endfunction

        function void accept_block(logic [7:0][1:0] kids, logic last);
            int      net;
            int      units;
            logic    neg;
            result_t site;
            net  = 0;
            site = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (kids[i] == TERN_POS)
                    net++;
                else if (kids[i] != TERN_ZERO)
                    net--;
            end
            site.coarse_state = TERN_ZERO;
            if (net != 0)
            begin
                neg   = net < 0;
                units = (neg ? -net : net) - 1;
                site.coarse_state = neg ? TERN_NEG : TERN_POS;
                if (units > 0)
                begin
                    if (neg)
                        owed_neg = owe_more(owed_neg, units);
                    else
                        owed_pos = owe_more(owed_pos, units);
                    if (count < SITES)
                    begin
                        spill_sign[tail] = neg;
                        spill_mag[tail]  = 3'(units);
                        tail  = (tail + 1) % SITES;
                        count++;
                    end
                end
            end
            else if (count > 0)
            begin
                neg = spill_sign[head];
                site.coarse_state = neg ? TERN_NEG : TERN_POS;
                if (neg)
                begin
                    if (owed_neg != 0)
                        owed_neg--;
                end
                else
                begin
                    if (owed_pos != 0)
                        owed_pos--;
                end
                if (spill_mag[head] <= 3'd1)
                begin
                    head = (head + 1) % SITES;
                    count--;
                end
                else
                    spill_mag[head]--;
            end
            site.site_last = last;
            if (last)
            begin
                site.unplaced_positive = owed_pos;
                site.unplaced_negative = owed_neg;
                site.conserved         = (owed_pos == 0) && (owed_neg == 0);
                clear_spills();
            end
            expected_sites.push_back(site);
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_site(logic [1:0] state, logic last, logic [CNT_W-1:0] unpl_pos,
                        logic [CNT_W-1:0] unpl_neg, logic cons);
            result_t want;
            if (expected_sites.size() == 0)
            begin
                flag_mismatch("result transaction with nothing expected");
                return;
            end
            want = expected_sites.pop_front();
            if (state !== want.coarse_state)
                flag_mismatch($sformatf("coarse_state %b, want %b", state, want.coarse_state));
            if (last !== want.site_last)
                flag_mismatch($sformatf("site_last %b, want %b", last, want.site_last));
            if (unpl_pos !== want.unplaced_positive)
                flag_mismatch($sformatf("unplaced_positive %0d, want %0d",
                                        unpl_pos, want.unplaced_positive));
            if (unpl_neg !== want.unplaced_negative)
                flag_mismatch($sformatf("unplaced_negative %0d, want %0d",
                                        unpl_neg, want.unplaced_negative));
            if (cons !== want.conserved)
                flag_mismatch($sformatf("conserved %b, want %b", cons, want.conserved));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic signed [1:0] child0;
    logic signed [1:0] child1;
    logic signed [1:0] child2;
    logic signed [1:0] child3;
    logic signed [1:0] child4;
    logic signed [1:0] child5;
    logic signed [1:0] child6;
    logic signed [1:0] child7;
    logic              last_block;
    logic              empty;
    logic              pop;
    logic signed [1:0] coarse_state;
    logic              site_last;
    logic [8:0]        unplaced_positive;
    logic [8:0]        unplaced_negative;
    logic              conserved;

    coarse_site_tracker board = new();
    logic send_idle;
    logic take_idle;
    int   blocks_sent;

    charge_conserving_ternary_blocking u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .child0            (child0),
        .child1            (child1),
        .child2            (child2),
        .child3            (child3),
        .child4            (child4),
        .child5            (child5),
        .child6            (child6),
        .child7            (child7),
        .last_block        (last_block),
        .empty             (empty),
        .pop               (pop),
        .coarse_state      (coarse_state),
        .site_last         (site_last),
        .unplaced_positive (unplaced_positive),
        .unplaced_negative (unplaced_negative),
        .conserved         (conserved)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.accept_block({child7, child6, child5, child4,
                                    child3, child2, child1, child0}, last_block);
            if (pop && !empty)
                board.check_site(coarse_state, site_last, unplaced_positive,
                                 unplaced_negative, conserved);
        end
    end

    function automatic logic [1:0] neg_pattern();
        return $urandom_range(0, 1) ? TERN_NEG : TERN_NEG_SAT;
    endfunction

    function automatic logic [7:0][1:0] kids_for_net(int net);
        logic [7:0][1:0] kids;
        logic [1:0]      tmp;
        int              mag;
        int              pairs;
        int              k;
        mag   = (net < 0) ? -net : net;
        pairs = $urandom_range(0, (8 - mag) / 2);
        for (int j = 0; j < 8; j++)
        begin
            if (j < mag)
                kids[j] = (net < 0) ? neg_pattern() : TERN_POS;
            else if (j < mag + pairs)
                kids[j] = TERN_POS;
            else if (j < mag + 2 * pairs)
                kids[j] = neg_pattern();
            else
                kids[j] = TERN_ZERO;
        end
        for (int j = 7; j > 0; j--)
        begin
            k       = $urandom_range(0, j);
            tmp     = kids[j];
            kids[j] = kids[k];
            kids[k] = tmp;
        end
        return kids;
    endfunction

    function automatic int random_net();
        return int'($urandom_range(0, 16)) - 8;
    endfunction

    task automatic send_block(input logic [7:0][1:0] kids, input logic last);
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        child0     <= kids[0];
        child1     <= kids[1];
        child2     <= kids[2];
        child3     <= kids[3];
        child4     <= kids[4];
        child5     <= kids[5];
        child6     <= kids[6];
        child7     <= kids[7];
        last_block <= last;
        push       <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        blocks_sent++;
    endtask

    task automatic send_mixed_lattice();
        int len;
        len = $urandom_range(1, 40);
        for (int n = 0; n < len; n++)
        begin
            if ($urandom_range(0, 4) < 2)
                send_block(kids_for_net(0), n == len - 1);
            else
                send_block(kids_for_net(random_net()), n == len - 1);
        end
    endtask

    task automatic send_overflow_lattice(input int sign);
        int len;
        len = $urandom_range(66, 80);
        for (int n = 0; n < len; n++)
        begin
            if ($urandom_range(0, 19) < 17)
                send_block(kids_for_net(sign * 8), 1'b0);
            else
                send_block(kids_for_net(sign * int'($urandom_range(2, 7))), 1'b0);
        end
        repeat ($urandom_range(0, 5))
            send_block(kids_for_net(0), 1'b0);
        send_block(kids_for_net(random_net()), 1'b1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(10, 30))
            send_block(16'($urandom), $urandom_range(0, 9) == 0);
    endtask

    task automatic send_random_lattice();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            send_overflow_lattice($urandom_range(0, 1) ? 1 : -1);
        else if (kind == 1)
            send_noise();
        else
            send_mixed_lattice();
    endtask

    task automatic send_directed();
        send_block({8{TERN_ZERO}}, 1'b0);
        send_block({8{TERN_POS}}, 1'b0);
        send_block({8{TERN_ZERO}}, 1'b0);
        send_block({8{TERN_ZERO}}, 1'b0);
        send_block({8{TERN_NEG_SAT}}, 1'b0);
        send_block({TERN_POS, {7{TERN_ZERO}}}, 1'b0);
        send_block({{7{TERN_ZERO}}, TERN_NEG}, 1'b0);
        send_block({TERN_POS, TERN_NEG, TERN_POS, TERN_NEG_SAT,
                    TERN_POS, TERN_NEG, TERN_POS, TERN_NEG_SAT}, 1'b0);
        send_block({8{TERN_NEG}}, 1'b0);
        send_block({8{TERN_ZERO}}, 1'b1);
        send_block({8{TERN_ZERO}}, 1'b1);
        send_block({{6{TERN_ZERO}}, TERN_POS, TERN_POS}, 1'b0);
        send_block({8{TERN_ZERO}}, 1'b1);
        send_block({8{TERN_NEG}}, 1'b1);
        send_block({{4{TERN_NEG_SAT}}, {4{TERN_NEG}}}, 1'b0);
        send_block({{3{TERN_POS}}, {5{TERN_ZERO}}}, 1'b1);
    endtask

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_charge_conserving_ternary_blocking: errors");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            int stall;
            @(posedge clk);
            if (take_idle && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 6);
                pop <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        child0      = TERN_ZERO;
        child1      = TERN_ZERO;
        child2      = TERN_ZERO;
        child3      = TERN_ZERO;
        child4      = TERN_ZERO;
        child5      = TERN_ZERO;
        child6      = TERN_ZERO;
        child7      = TERN_ZERO;
        last_block  = 1'b0;
        send_idle   = 1'b0;
        take_idle   = 1'b0;
        blocks_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_block({8{TERN_ZERO}}, 1'b1);

        send_idle = 1'b1;
        take_idle = 1'b1;
        blocks_sent = 0;
        send_overflow_lattice(1);
        send_overflow_lattice(-1);
        while (blocks_sent < RANDOM_ITEMS - CALM_ITEMS)
        begin
            send_idle = $urandom_range(0, 9) < 7;
            take_idle = $urandom_range(0, 9) < 7;
            send_random_lattice();
        end
        send_idle = 1'b0;
        take_idle = 1'b0;
        while (blocks_sent < RANDOM_ITEMS)
            send_mixed_lattice();
        push <= 1'b0;

        while (board.expected_sites.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.mismatches == 0)
            $display("tb_charge_conserving_ternary_blocking: clean");
        else
            $display("tb_charge_conserving_ternary_blocking: errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cctb_pkg.sv
hw/rtl/cctb_fifo.sv
hw/rtl/cctb_front.sv
hw/rtl/cctb_back.sv
hw/rtl/charge_conserving_ternary_blocking.sv
hw/rtl/cctb_checker.sv
tb/tb_charge_conserving_ternary_blocking.sv
